FILE: rtl/dcrf_pkg.sv
// Shared types and constants for the drift-corrected resampling FIFO.
`default_nettype none
package dcrf_pkg;

  // Fractional bits of the phase and of the ratio.
  localparam int unsigned PhaseBits = 26;

  // Reset value of the nominal ratio (1.0 in Q6.26).
  localparam logic [31:0] NominalReset = 32'd67108864;

  // Configuration register indexes.
  localparam logic [1:0] CfgNominal = 2'd0;
  localparam logic [1:0] CfgChannels = 2'd1;

  // Input item kinds.
  localparam logic KindPush = 1'b0;
  localparam logic KindDrain = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle,
    StPushOut,
    StRatio,
    StFrRead,
    StFrMul,
    StFrAdd,
    StEmFetch,
    StEmSend
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/drift_corrected_resampling_fifo.sv
// Top level: ring buffer, ratio correction, interpolation sequencer and output stage.
// Push: the result is loaded from StPushOut once the output slot is free; the next item is taken once it leaves.
// Drain of N frames: first the ratio (registered scaling, then a reciprocal multiply),
//   then each frame is read, multiplied and added, or counted as an underrun, then each result is fetched and sent.
// One item at a time; sending waits while the output is stalled.
// Reset (rst_ni low, asynchronous) clears positions, phase, counters and control registers;
//   the frame store and the payload registers are not cleared; the store needs no clearing pass.
`default_nettype none
module drift_corrected_resampling_fifo #(
  parameter int unsigned CAPACITY_FRAMES = 4096,
  parameter int unsigned MAX_REQUEST = 64,
  parameter int unsigned SAMPLE_BITS = 24,
  localparam int unsigned OutBits = 2 * SAMPLE_BITS + 13 + 160,
  localparam int unsigned OutBytes = (OutBits + 7) / 8,
  localparam int unsigned InBits = 2 * SAMPLE_BITS + 7,
  localparam int unsigned InBytes = (InBits + 7) / 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Input items.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: sample_left, sample_right, request_count, zero pad.
  input  wire logic [8*InBytes-1:0]   s_axis_tdata,
  // tuser: kind.
  input  wire logic                   s_axis_tuser,
  // Result items.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata: out_left, out_right, buffered_frames, overrun_total, underrun_total,
  //   received_total, delivered_total, step_ratio, zero pad.
  output logic [8*OutBytes-1:0]       m_axis_tdata,
  // tuser: frame_valid, accepted.
  output logic [1:0]                  m_axis_tuser,
  output logic                        m_axis_tlast,
  // Configuration writes.
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [31:0]            cfg_data_i
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned PB = dcrf_pkg::PhaseBits;
  localparam int unsigned AW = $clog2(CAPACITY_FRAMES);
  localparam int unsigned HW = AW + 1;
  localparam int unsigned PW = 32 + HW;
  localparam int unsigned Den = 400 * CAPACITY_FRAMES;
  localparam int unsigned IW = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
  localparam logic [HW-1:0] Cap = HW'(CAPACITY_FRAMES);
  localparam logic [6:0] MaxReq = 7'(MAX_REQUEST);

  // Registers and state.
  dcrf_pkg::state_e state_q, state_d;
  logic [31:0]   nominal_q;
  logic [1:0]    chan_q;
  logic [HW-1:0] wp_q, rp_q;
  logic [PB-1:0] phase_q;
  logic [31:0]   ratio_q;
  logic [31:0]   ovr_q, und_q, rcv_q, dlv_q;
  logic [6:0]    req_q, fcnt_q, ecnt_q;
  logic          epos_q;
  logic          push_ok_q;
  logic          div_start_q;

  logic [2*SB-1:0] frame_store [CAPACITY_FRAMES];
  logic [2*SB-1:0] rd_a_q, rd_b_q;
  logic [2*SB:0]   res_buf [MAX_REQUEST];
  logic [2*SB:0]   res_rd_q;

  logic              out_valid_q;
  logic [8*OutBytes-1:0] out_data_q;
  logic [1:0]        out_user_q;
  logic              out_last_q;

  // Decoded input item.
  logic              kind;
  logic signed [SB-1:0] in_left, in_right;
  logic [6:0]        in_req, req_sat;
  assign kind = s_axis_tuser;
  assign in_left = s_axis_tdata[SB-1:0];
  assign in_right = s_axis_tdata[2*SB-1:SB];
  assign in_req = s_axis_tdata[2*SB+6:2*SB];
  assign req_sat = (in_req > MaxReq) ? MaxReq : in_req;

  logic in_xfer, out_xfer, stereo, slot_free;
  assign s_axis_tready = (state_q == dcrf_pkg::StIdle) && !out_valid_q;
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign stereo = chan_q[1];
  assign cfg_ready_o = 1'b1;

  // Fill level and its error around half capacity.
  logic [HW-1:0] held;
  logic [HW:0]   twice_held;
  logic [HW-1:0] mag;
  logic          e_pos;
  assign held = wp_q - rp_q;
  assign twice_held = {held, 1'b0};
  assign e_pos = twice_held >= {1'b0, Cap};
  assign mag = e_pos ? HW'(twice_held - {1'b0, Cap}) : HW'({1'b0, Cap} - twice_held);

  logic [PW-1:0] scaled;
  logic [PW-1:0] scaled_q;
  assign scaled = PW'(nominal_q) * PW'(mag) + PW'(Den / 2);

  // Correction quotient. The one percent limit never binds: the fill error is at most the
  // capacity, so the quotient stays at or below nominal / 400 rounded.
  logic [31:0] qcap;
  dcrf_cdiv #(.DividendBits(PW), .ShiftBits(AW + 2)) u_corr_div (
    .clk_i, .en_i(div_start_q), .dividend_i(scaled_q), .quotient_o(qcap)
  );

  logic [32:0] up_sum;
  logic [31:0] new_ratio;
  assign up_sum = {1'b0, nominal_q} + {1'b0, qcap};
  assign new_ratio = epos_q ? (up_sum[32] ? 32'hFFFF_FFFF : up_sum[31:0]) : nominal_q - qcap;

  // Two channel lanes; the merge writes both results into one entry.
  logic signed [SB-1:0] lane_l, lane_r;
  logic lane_en;
  assign lane_en = (state_q == dcrf_pkg::StFrMul);
  dcrf_lane #(.SampleBits(SB)) u_lane_l (
    .clk_i, .en_i(lane_en), .a_i(rd_a_q[SB-1:0]), .b_i(rd_b_q[SB-1:0]),
    .phase_i(phase_q), .result_o(lane_l)
  );
  dcrf_lane #(.SampleBits(SB)) u_lane_r (
    .clk_i, .en_i(lane_en), .a_i(rd_a_q[2*SB-1:SB]), .b_i(rd_b_q[2*SB-1:SB]),
    .phase_i(phase_q), .result_o(lane_r)
  );

  // Phase advance and capped read step.
  logic [32:0]   ph_sum;
  logic [6:0]    whole;
  logic [HW-1:0] step;
  assign ph_sum = {7'd0, phase_q} + {1'b0, ratio_q};
  assign whole = ph_sum[32:PB];
  assign step = (HW'(whole) > held) ? held : HW'(whole);

  logic frame_last, emit_last;
  assign frame_last = (fcnt_q == req_q - 7'd1);
  assign emit_last = (ecnt_q == req_q - 7'd1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dcrf_pkg::StIdle: begin
        if (in_xfer) begin
          if (kind == dcrf_pkg::KindPush) begin
            state_d = dcrf_pkg::StPushOut;
          end else if (in_req != 7'd0) begin
            state_d = dcrf_pkg::StRatio;
          end
        end
      end
      dcrf_pkg::StPushOut: begin
        if (slot_free) state_d = dcrf_pkg::StIdle;
      end
      dcrf_pkg::StRatio: begin
        if (!div_start_q) state_d = dcrf_pkg::StFrRead;
      end
      dcrf_pkg::StFrRead: begin
        if (held < HW'(2)) begin
          state_d = frame_last ? dcrf_pkg::StEmFetch : dcrf_pkg::StFrRead;
        end else begin
          state_d = dcrf_pkg::StFrMul;
        end
      end
      dcrf_pkg::StFrMul: state_d = dcrf_pkg::StFrAdd;
      dcrf_pkg::StFrAdd: state_d = frame_last ? dcrf_pkg::StEmFetch : dcrf_pkg::StFrRead;
      dcrf_pkg::StEmFetch: state_d = dcrf_pkg::StEmSend;
      dcrf_pkg::StEmSend: begin
        if (slot_free) state_d = emit_last ? dcrf_pkg::StIdle : dcrf_pkg::StEmFetch;
      end
      default: state_d = dcrf_pkg::StIdle;
    endcase
  end

  // Output selection: a push result or a buffered drain result, with common fields.
  logic          load_out;
  logic [2*SB:0] sel_entry;
  logic [1:0]    sel_user;
  logic          sel_last;
  always_comb begin
    load_out = 1'b0;
    sel_entry = '0;
    sel_user = 2'b00;
    sel_last = 1'b0;
    case (state_q)
      dcrf_pkg::StPushOut: begin
        load_out = slot_free;
        sel_user = {push_ok_q, 1'b0};
        sel_last = 1'b1;
      end
      dcrf_pkg::StEmSend: begin
        load_out = slot_free;
        sel_entry = res_rd_q;
        sel_user = {1'b0, res_rd_q[2*SB]};
        sel_last = emit_last;
      end
      default: load_out = 1'b0;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcrf_pkg::StIdle;
      nominal_q <= dcrf_pkg::NominalReset;
      chan_q <= 2'd2;
      wp_q <= '0;
      rp_q <= '0;
      phase_q <= '0;
      ratio_q <= dcrf_pkg::NominalReset;
      ovr_q <= '0;
      und_q <= '0;
      rcv_q <= '0;
      dlv_q <= '0;
      req_q <= '0;
      fcnt_q <= '0;
      ecnt_q <= '0;
      epos_q <= 1'b0;
      push_ok_q <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      div_start_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == dcrf_pkg::CfgNominal) nominal_q <= cfg_data_i;
        if (cfg_index_i == dcrf_pkg::CfgChannels) chan_q <= cfg_data_i[1:0];
      end
      // Accepted item.
      if (in_xfer) begin
        if (kind == dcrf_pkg::KindPush) begin
          push_ok_q <= held < Cap;
          if (held < Cap) begin
            wp_q <= wp_q + 1'b1;
            rcv_q <= rcv_q + 32'd1;
          end else begin
            ovr_q <= ovr_q + 32'd1;
          end
        end else if (in_req != 7'd0) begin
          req_q <= req_sat;
          fcnt_q <= '0;
          ecnt_q <= '0;
          epos_q <= e_pos;
          div_start_q <= 1'b1;
        end
      end
      if (state_q == dcrf_pkg::StRatio && state_d == dcrf_pkg::StFrRead) begin
        ratio_q <= new_ratio;
      end
      // Underrun frame.
      if (state_q == dcrf_pkg::StFrRead && held < HW'(2)) begin
        und_q <= und_q + 32'd1;
        fcnt_q <= fcnt_q + 7'd1;
      end
      // Produced frame.
      if (state_q == dcrf_pkg::StFrAdd) begin
        dlv_q <= dlv_q + 32'd1;
        phase_q <= ph_sum[PB-1:0];
        rp_q <= rp_q + step;
        fcnt_q <= fcnt_q + 7'd1;
      end
      if (state_q == dcrf_pkg::StEmSend && slot_free) begin
        ecnt_q <= ecnt_q + 7'd1;
      end
      // Output stage.
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scaled fill error, captured when a drain request is taken.
  always_ff @(posedge clk_i) begin
    if (in_xfer && kind == dcrf_pkg::KindDrain) begin
      scaled_q <= scaled;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= (8*OutBytes)'({ratio_q, dlv_q, rcv_q, und_q,
                                   ovr_q, 13'(held), sel_entry[2*SB-1:0]});
      out_user_q <= sel_user;
      out_last_q <= sel_last;
    end
  end

  // Frame store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (in_xfer && kind == dcrf_pkg::KindPush && held < Cap) begin
      frame_store[wp_q[AW-1:0]] <= {stereo ? in_right : SB'(0), in_left};
    end
    rd_a_q <= frame_store[rp_q[AW-1:0]];
    rd_b_q <= frame_store[AW'(rp_q[AW-1:0] + 1'b1)];
  end

  // Result buffer: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (state_q == dcrf_pkg::StFrAdd) begin
      res_buf[fcnt_q[IW-1:0]] <= {1'b1, stereo ? lane_r : SB'(0), lane_l};
    end else if (state_q == dcrf_pkg::StFrRead && held < HW'(2)) begin
      res_buf[fcnt_q[IW-1:0]] <= '0;
    end
    res_rd_q <= res_buf[ecnt_q[IW-1:0]];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;
  assign m_axis_tlast = out_last_q;

endmodule
`default_nettype wire

FILE: rtl/dcrf_cdiv.sv
// Division by a constant of the form 100 * 2^ShiftBits: a shift, then a reciprocal multiply.
`default_nettype none
module dcrf_cdiv #(
  parameter int unsigned DividendBits = 45,
  parameter int unsigned ShiftBits = 14
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [DividendBits-1:0] dividend_i,
  output logic [31:0]                  quotient_o
);

  // floor(x / 100) equals (x * Recip100) >> 37 for every 32-bit x.
  localparam logic [31:0] Recip100 = 32'h51EB_851F;

  logic [31:0] src;
  logic [63:0] prod_q;

  // Drop the power-of-two part of the divisor first.
  assign src = 32'(dividend_i[DividendBits-1:ShiftBits]);

  // Reciprocal product, registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {32'd0, src} * {32'd0, Recip100};
    end
  end

  assign quotient_o = {5'd0, prod_q[63:37]};

endmodule
`default_nettype wire

FILE: rtl/dcrf_lane.sv
// One channel lane: linear interpolation between two adjacent samples.
`default_nettype none
module dcrf_lane #(
  parameter int unsigned SampleBits = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [SampleBits-1:0]        a_i,
  input  wire logic signed [SampleBits-1:0]        b_i,
  input  wire logic [dcrf_pkg::PhaseBits-1:0]      phase_i,
  output logic signed [SampleBits-1:0]             result_o
);

  localparam int unsigned PB = dcrf_pkg::PhaseBits;
  localparam int unsigned ProdBits = SampleBits + 1 + PB + 1;

  logic signed [SampleBits:0]     diff;
  logic signed [ProdBits-1:0]     prod_q;
  logic signed [SampleBits-1:0]   a_q;
  logic signed [ProdBits-1:0]     rounded;
  logic signed [ProdBits-1:0]     shifted;

  assign diff = SampleBits'(b_i) - SampleBits'(a_i) == 0 ? '0 :
                $signed({b_i[SampleBits-1], b_i}) - $signed({a_i[SampleBits-1], a_i});

  // Product of the difference and the phase, registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdBits'(diff) * ProdBits'($signed({1'b0, phase_i}));
      a_q <= a_i;
    end
  end

  // Round half up, floor toward minus infinity, then add the base sample.
  assign rounded = prod_q + (ProdBits'(1) <<< (PB - 1));
  assign shifted = rounded >>> PB;
  assign result_o = SampleBits'(a_q + SampleBits'(shifted));

endmodule
`default_nettype wire

FILE: rtl/dcrf_checker.sv
// Port-level checks on the resampling FIFO, bound to the top level.
`default_nettype none
module dcrf_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [223:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  // A stalled result keeps its valid.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No new item is taken while a result still waits.
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while output pending");

  // Frame-valid and push-accepted never appear together.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("conflicting result flags");

  // A frame that was not produced carries zero samples.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[47:0] == 48'd0)
    else $error("unproduced frame has nonzero samples");

endmodule

bind drift_corrected_resampling_fifo dcrf_checker u_dcrf_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
